### src/pell_prime_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Pell/prime classifier
// Shared macros for concurrent checks, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PELL_PRIME_CLASSIFIER_TOP_ASSERT_SVH
`define PELL_PRIME_CLASSIFIER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("classifier check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("classifier check failed");

`endif

### src/ppc_pkg.sv
// ----------------------------------------------------------------------------
// Pell/prime classifier package
// Types shared between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } ppc_div_stat_type;

   // Result bit positions on the response beat.
   localparam int unsigned RSP_PELL_BIT  = 0;
   localparam int unsigned RSP_PRIME_BIT = 1;
   localparam int unsigned RSP_DATA_W    = 8;

endpackage

`default_nettype wire

### src/ppc_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppc_div
   import ppc_pkg::*;
#(
   parameter int unsigned WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic      [WIDTH-1:0] quotient,
   output logic      [WIDTH-1:0] remainder,
   output ppc_div_stat_type      status
);

   localparam int unsigned CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   rem_shift;
   logic [WIDTH:0]   rem_diff;

   // Shift in the next dividend bit and try to subtract the divisor.
   assign rem_shift = {rem_ff, quo_ff[WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!rem_diff[WIDTH]) begin
            rem_in = rem_diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

### src/pell_prime_classifier_top.sv
// ----------------------------------------------------------------------------
// Pell/prime classifier
// Flags whether a signed integer is a Pell number and whether it is prime.
// ----------------------------------------------------------------------------
// Usage: one signed value arrives per beat on the req_ stream; one beat with
// two flags leaves on the rsp_ stream for every value taken.
// Each item first walks the Pell sequence 2, 5, 12, 29, ... with an adder,
// one term per cycle, then runs trial division on a shared restoring divider
// that delivers one quotient bit per cycle.
// Trial division runs one divider operation for every trial divisor from 2
// up to the square root of the value; a 32-bit prime near the top of the
// range needs about 46,000 divisors. Negative values skip the Pell walk and
// the division, and zero and one skip the division.
// Throughput: one item at a time; req_tready is high only while the sequencer
// is idle. A finished result sits in the output register, so the next value
// may be taken while the previous result still waits for rsp_tready.
// If the receiver stalls and a second result is ready, the sequencer holds it
// until the output register frees up.
// Reset clears the sequencer and the output valid; no state carries over
// from one item to the next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pell_prime_classifier_top
   import ppc_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // Fields from bit 0 up: value (VALUE_WIDTH bits, signed), zero fill.
   input  wire logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // Fields from bit 0 up: is_pell (1 bit), is_prime (1 bit), zero fill.
   output logic [RSP_DATA_W-1:0]                      rsp_tdata
);

   localparam int unsigned W = VALUE_WIDTH;

   // Sequencer states.
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_PELL      = 3'd1;
   localparam logic [2:0] S_PRIME     = 3'd2;
   localparam logic [2:0] S_DIV_START = 3'd3;
   localparam logic [2:0] S_DIV_WAIT  = 3'd4;
   localparam logic [2:0] S_DONE      = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic [W-1:0] n_ff, n_in;
   logic [W:0]   prev_ff, prev_in;
   logic [W:0]   cur_ff, cur_in;
   logic [W-1:0] d_ff, d_in;
   logic         pell_ff, pell_in;
   logic         prime_ff, prime_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [1:0]   rsp_flags_ff, rsp_flags_in;

   logic [W-1:0]     div_quo;
   logic [W-1:0]     div_rem;
   ppc_div_stat_type div_stat;
   logic             div_start;
   logic             req_beat;
   logic [W-1:0]     req_value;

   assign req_value = req_tdata[W-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign div_start  = (state_ff == S_DIV_START);

   ppc_div #(
      .WIDTH(W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .quotient (div_quo),
      .remainder(div_rem),
      .status   (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      d_in         = d_ff;
      pell_in      = pell_ff;
      prime_in     = prime_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_flags_in = rsp_flags_ff;

      // The output register empties when the receiver takes the beat.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               n_in     = req_value;
               prev_in  = (W+1)'(1);
               cur_in   = (W+1)'(2);
               d_in     = W'(2);
               pell_in  = 1'b0;
               prime_in = 1'b0;
               // Negative values are neither Pell nor prime.
               if (req_value[W-1]) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_PELL;
               end
            end
         end
         S_PELL: begin
            // One is Pell by definition; otherwise step the sequence until
            // a term reaches the value. Terms stay below three times the
            // largest value, so W+1 bits never wrap.
            if (n_ff == W'(1)) begin
               pell_in  = 1'b1;
               state_in = S_PRIME;
            end else if (cur_ff < {1'b0, n_ff}) begin
               cur_in  = (cur_ff << 1) + prev_ff;
               prev_in = cur_ff;
            end else begin
               pell_in  = (cur_ff == {1'b0, n_ff});
               state_in = S_PRIME;
            end
         end
         S_PRIME: begin
            if (n_ff <= W'(1)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DIV_START;
            end
         end
         S_DIV_START: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               // Stop once the divisor passes the square root (d > n / d).
               if (d_ff > div_quo) begin
                  prime_in = 1'b1;
                  state_in = S_DONE;
               end else if (div_rem == '0) begin
                  prime_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  d_in     = d_ff + W'(1);
                  state_in = S_DIV_START;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in                = 1'b1;
               rsp_flags_in[RSP_PELL_BIT]  = pell_ff;
               rsp_flags_in[RSP_PRIME_BIT] = prime_ff;
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      d_ff         <= d_in;
      pell_ff      <= pell_in;
      prime_ff     <= prime_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2){1'b0}}, rsp_flags_ff};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`include "pell_prime_classifier_top_assert.svh"

   // A taken beat always moves the sequencer out of idle.
   `PPC_ASSERT_NEXT(a_busy_after_req, req_beat, state_ff != S_IDLE)
   // Starting the divider makes it busy in the next cycle.
   `PPC_ASSERT_NEXT(a_div_runs, div_start, div_stat.busy)
   // The divider only reports completion while the sequencer waits for it.
   `PPC_ASSERT_SAME(a_done_in_wait, div_stat.done, state_ff == S_DIV_WAIT)
   // While idle, the divider has no operation in flight.
   `PPC_ASSERT_SAME(a_idle_div_quiet, req_tready, !div_stat.busy && !div_stat.done)

endmodule

`default_nettype wire

### bench/tb_pell_prime_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Pell/prime classifier
// Drives signed values on the request stream and checks both flags of every
// response beat against a local predictor. Both streams idle at random. One
// phase stalls the response side for a long stretch, and another pauses the
// sender until every outstanding response has been checked.
// ----------------------------------------------------------------------------

module tb_pell_prime_classifier_top;
   import ppc_pkg::*;

   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned REQ_W       = ((VALUE_W + 7) / 8) * 8;
   localparam int unsigned HOLD_CYCLES = 4000;
   localparam int unsigned TAIL_CYCLES = 100;
   localparam int unsigned N_RANDOM    = 70;

   // One expected response beat, kept with the value that caused it.
   typedef struct {
      logic [VALUE_W-1:0] value;
      bit                 is_pell;
      bit                 is_prime;
   } flag_pair_type;

   // Works out both flags for one value, using 64-bit arithmetic so that the
   // Pell walk never wraps.
   function automatic flag_pair_type classify_value(logic [VALUE_W-1:0] value);
      flag_pair_type res;
      logic [63:0] n;
      logic [63:0] prev;
      logic [63:0] cur;
      logic [63:0] nxt;
      logic [63:0] d;
      bit          done;
      res.value    = value;
      res.is_pell  = 1'b0;
      res.is_prime = 1'b0;
      // Zero and negative values leave both flags clear.
      if (value[VALUE_W-1] == 1'b0) begin
         n = {{(64 - VALUE_W){1'b0}}, value};
         if (n == 64'd1) begin
            res.is_pell = 1'b1;
         end else begin
            prev = 64'd1;
            cur  = 64'd2;
            done = 1'b0;
            while (!done && cur < n) begin
               // A term that would not fit lies above every possible value.
               if (cur > (64'hFFFF_FFFF_FFFF_FFFF - prev) / 64'd2) begin
                  done = 1'b1;
               end else begin
                  nxt  = 64'd2 * cur + prev;
                  prev = cur;
                  cur  = nxt;
               end
            end
            res.is_pell = !done && (cur == n);
         end
         if (n > 64'd1) begin
            res.is_prime = 1'b1;
            for (d = 64'd2; d <= n / d && res.is_prime; d++) begin
               if (n % d == 64'd0) begin
                  res.is_prime = 1'b0;
               end
            end
         end
      end
      return res;
   endfunction

   // Holds the flags still owed by the block, oldest first.
   class flag_scoreboard;
      flag_pair_type expected_flags[$];
      int unsigned   failures;

      function new();
         failures = 0;
      endfunction

      function void note_value(logic [VALUE_W-1:0] value);
         expected_flags.push_back(classify_value(value));
      endfunction

      function void check_flags(logic [RSP_DATA_W-1:0] data);
         flag_pair_type exp_pair;
         logic [RSP_DATA_W-1:0] fill;
         if (expected_flags.size() == 0) begin
            $display("%0t: unexpected response beat, actual 0x%0h", $realtime, data);
            failures++;
            return;
         end
         exp_pair = expected_flags.pop_front();
         fill = data;
         fill[RSP_PELL_BIT]  = 1'b0;
         fill[RSP_PRIME_BIT] = 1'b0;
         if (data[RSP_PELL_BIT] !== exp_pair.is_pell) begin
            $display("%0t: is_pell for %0d expected %0d actual %0b", $realtime,
                     $signed(exp_pair.value), exp_pair.is_pell, data[RSP_PELL_BIT]);
            failures++;
         end
         if (data[RSP_PRIME_BIT] !== exp_pair.is_prime) begin
            $display("%0t: is_prime for %0d expected %0d actual %0b", $realtime,
                     $signed(exp_pair.value), exp_pair.is_prime, data[RSP_PRIME_BIT]);
            failures++;
         end
         if (fill !== '0) begin
            $display("%0t: fill bits for %0d expected 0 actual 0x%0h", $realtime,
                     $signed(exp_pair.value), fill);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_flags.size();
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   flag_scoreboard board = new();

   // When set, both streams run without idle cycles.
   bit steady_mode = 1'b0;
   // Asks the response side for one long stall.
   bit rsp_hold_req = 1'b0;

   pell_prime_classifier_top #(
      .VALUE_WIDTH(VALUE_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The limit leaves a wide margin over the whole regression.
   initial begin
      #400_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Offers one value after a random idle gap and waits until it is taken.
   // The valid stays high between back-to-back beats.
   task automatic send_value(logic [VALUE_W-1:0] value);
      int unsigned gap;
      gap = steady_mode ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_value(value);
   endtask

   // Pauses the sender until every owed response beat has been checked.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Term of the sequence 1, 2, 5, 12, 29, ... at the given index.
   function automatic logic [VALUE_W-1:0] pell_term(int unsigned idx);
      logic [63:0] prev;
      logic [63:0] cur;
      logic [63:0] nxt;
      prev = 64'd0;
      cur  = 64'd1;
      for (int unsigned i = 0; i < idx; i++) begin
         nxt  = 64'd2 * cur + prev;
         prev = cur;
         cur  = nxt;
      end
      return cur[VALUE_W-1:0];
   endfunction

   // Random values are kept cheap for trial division: small values, negative
   // values, and large values with a small factor reach every bit without
   // long divider runs.
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned pick;
      int unsigned idx;
      logic [VALUE_W-1:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         v = $urandom_range(0, 4095);
      end else if (pick < 60) begin
         // Pell terms and their neighbors; the neighbors only where the divider
         // run stays short.
         idx = $urandom_range(0, 17);
         v = pell_term(idx);
         if (idx <= 13) begin
            v = v + VALUE_W'($urandom_range(0, 2)) - VALUE_W'(1);
         end
      end else if (pick < 75) begin
         v = $urandom();
         v[VALUE_W-1] = 1'b1;
      end else if (pick < 83) begin
         v = $urandom();
         v[VALUE_W-1] = 1'b0;
         v[0] = 1'b0;
      end else if (pick < 90) begin
         v = VALUE_W'($urandom_range(1, 715_827_882)) * VALUE_W'(3);
      end else begin
         v = $urandom_range(4096, 65535);
      end
      return v;
   endfunction

   // Response side: random stalls per beat, plus one long stall on request.
   initial begin
      int unsigned gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         gap = steady_mode ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_flags(rsp_tdata);
      end
   end

   // Main sequence: reset, directed values, a burst with no idling, the long
   // response stall, a drained pause, then the random bulk.
   initial begin
      logic [VALUE_W-1:0] directed[$];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes, zero, one, the smallest primes, Pell terms that are
      // and are not prime, the largest Pell term in range, and its neighbor.
      directed = '{32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd2, 32'd3,
                   32'd4, 32'd5, 32'd12, 32'd29, 32'd70, 32'd169, 32'd985,
                   32'd5741, 32'd997, 32'd1_000_003, 32'd65536, 32'h5555_5554,
                   32'd93_222_358, 32'd543_339_720, 32'd1_311_738_121,
                   32'd1_311_738_120, 32'h7FFF_FFFE, 32'h7FFF_FFFF};
      foreach (directed[i]) send_value(directed[i]);

      // Back-to-back beats on both sides.
      steady_mode = 1'b1;
      repeat (20) send_value(pick_value());
      steady_mode = 1'b0;

      // Long response stall: the output register and the sequencer fill up and
      // the request side has to back off while values keep coming.
      wait_drained();
      rsp_hold_req = 1'b1;
      repeat (8) send_value($urandom_range(0, 255));

      // The sender waits for every owed beat before going on.
      wait_drained();

      repeat (N_RANDOM - 20) send_value(pick_value());
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.failures == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
